/* sv/bccf_pkg.sv */
`timescale 1ns / 1ps

package bccf_pkg;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DEGN = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic CFG_BEAM_X = 1'b0;
    localparam logic CFG_BEAM_Y = 1'b1;

    localparam int CW_MAX = 32;

endpackage

/* sv/bccf_mul.sv */
`timescale 1ns / 1ps

// Signed multiplier split into two partial products over the lower and upper
// halves of the wide operand. The partial products are registered in the
// first stage and summed into the registered product in the second.
module bccf_mul
    import bccf_pkg::*;
#(
    parameter int AW = 48,
    parameter int BW = 24,
    parameter int PW = AW + BW
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [PW-1:0] o_p
);

    localparam int LW  = (AW + 1) / 2;
    localparam int HW  = AW - LW;
    localparam int LPW = LW + 1 + BW;
    localparam int HPW = HW + BW;

    logic signed [LPW-1:0] r_lo;
    logic signed [HPW-1:0] r_hi;
    logic signed [PW-1:0]  r_p;

    always_ff @(posedge i_clk) begin
        r_lo <= LPW'(signed'({1'b0, i_a[LW-1:0]})) * LPW'(i_b);
        r_hi <= HPW'(signed'(i_a[AW-1:LW])) * HPW'(i_b);
        r_p  <= (PW'(r_hi) <<< LW) + PW'(r_lo);
    end

    assign o_p = r_p;

endmodule

/* sv/bccf_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage.
module bccf_div
    import bccf_pkg::*;
#(
    parameter int NW = 96,
    parameter int DW = 48,
    parameter int TW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [NW-1:0] r_n [NW+1];
    logic [DW:0]   r_r [NW+1];
    logic [DW-1:0] r_d [NW+1];
    logic [TW-1:0] r_t [NW+1];

    always_comb begin
        r_n[0] = i_num;
        r_r[0] = '0;
        r_d[0] = i_den;
        r_t[0] = i_tag;
    end

    for (genvar g = 0; g < NW; g++) begin : g_st
        logic [DW+1:0] n_sh;
        logic [DW+1:0] n_df;
        always_comb begin
            n_sh = {r_r[g], r_n[g][NW-1]};
            n_df = n_sh - {2'b00, r_d[g]};
        end
        always_ff @(posedge i_clk) begin
            r_d[g+1] <= r_d[g];
            if (!i_rst_n) begin
                r_t[g+1] <= '0;
            end else begin
                r_t[g+1] <= r_t[g];
            end
            if (!n_df[DW+1]) begin
                r_r[g+1] <= n_df[DW:0];
                r_n[g+1] <= {r_n[g][NW-2:0], 1'b1};
            end else begin
                r_r[g+1] <= n_sh[DW:0];
                r_n[g+1] <= {r_n[g][NW-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_n[NW];
    assign o_tag = r_t[NW];

endmodule

/* sv/bccf_sqrt.sv */
`timescale 1ns / 1ps

// Pipelined integer square root with round to nearest, one result bit
// per stage.
module bccf_sqrt
    import bccf_pkg::*;
#(
    parameter int TW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [63:0]   i_s,
    input  logic [TW-1:0] i_tag,
    output logic [32:0]   o_root,
    output logic [TW-1:0] o_tag
);

    logic [63:0]   r_rem [33];
    logic [31:0]   r_q   [33];
    logic [TW-1:0] r_t   [33];
    logic [32:0]   r_root;
    logic [TW-1:0] r_tag;

    always_comb begin
        r_rem[0] = i_s;
        r_q[0]   = '0;
        r_t[0]   = i_tag;
    end

    for (genvar g = 0; g < 32; g++) begin : g_st
        logic [65:0] n_trial;
        logic [65:0] n_diff;
        always_comb begin
            n_trial = ({34'd0, r_q[g]} << (32 - g)) + (66'd1 << (62 - 2 * g));
            n_diff  = {2'b00, r_rem[g]} - n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_t[g+1] <= '0;
            end else begin
                r_t[g+1] <= r_t[g];
            end
            if (!n_diff[65]) begin
                r_rem[g+1] <= n_diff[63:0];
                r_q[g+1]   <= r_q[g] | (32'd1 << (31 - g));
            end else begin
                r_rem[g+1] <= r_rem[g];
                r_q[g+1]   <= r_q[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= r_t[32];
        end
        r_root <= (r_rem[32] > {32'd0, r_q[32]}) ? {1'b0, r_q[32]} + 33'd1
                                                  : {1'b0, r_q[32]};
    end

    assign o_root = r_root;
    assign o_tag  = r_tag;

endmodule

/* sv/beam_constrained_circle_fit_core.sv */
`timescale 1ns / 1ps

// Pipeline after the edge that accepts start (COORD_WIDTH = 20): offset, norm,
// two multiply and magnitude stages, then 66 divider stages (one per quotient
// bit), a center stage, 33 square-root stages and the output register that
// drives o_valid.
// Throughput: one transaction per cycle; busy is never raised and the receiver cannot stall.
// Reset: synchronous active-low i_rst_n clears the beam registers and all valid bits.
module beam_constrained_circle_fit_core
    import bccf_pkg::*;
#(
    parameter int COORD_WIDTH = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    output logic                          o_valid,
    output logic signed [31:0]            o_center_x,
    output logic signed [31:0]            o_center_y,
    output logic [30:0]                   o_radius,
    output logic [1:0]                    o_fit_status
);

    // Difference width, squared norm width, numerator and denominator widths.
    localparam int DW = COORD_WIDTH + 1;
    localparam int NW = 2 * DW + 1;
    localparam int QW = NW + DW + 1;
    localparam int EW = 2 * DW + 2;
    // Magnitude widths that the dividers work on.
    localparam int MW = QW + 1;
    // Tag carried alongside each divider: valid, degenerate, sign, beam.
    localparam int TW = 3 + COORD_WIDTH;

    assign busy = 1'b0;

    logic signed [COORD_WIDTH-1:0] r_beam_x;
    logic signed [COORD_WIDTH-1:0] r_beam_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_x <= '0;
            r_beam_y <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BEAM_X) begin
                r_beam_x <= i_cfg_data;
            end else begin
                r_beam_y <= i_cfg_data;
            end
        end
    end

    // Stage 1: hit offsets relative to the beam.
    logic                 r_v1;
    logic signed [DW-1:0] r_d1x, r_d1y, r_d2x, r_d2y;
    logic signed [COORD_WIDTH-1:0] r_bx1, r_by1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_d1x <= DW'(i_first_x)  - DW'(r_beam_x);
        r_d1y <= DW'(i_first_y)  - DW'(r_beam_y);
        r_d2x <= DW'(i_second_x) - DW'(r_beam_x);
        r_d2y <= DW'(i_second_y) - DW'(r_beam_y);
        r_bx1 <= r_beam_x;
        r_by1 <= r_beam_y;
    end

    // Stage 2: squared norms and cross terms.
    logic                 r_v2;
    logic signed [NW-1:0] r_n1, r_n2;
    logic signed [EW-1:0] r_den;
    logic signed [DW-1:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [COORD_WIDTH-1:0] r_bx2, r_by2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_n1  <= NW'(r_d1x) * NW'(r_d1x) + NW'(r_d1y) * NW'(r_d1y);
        r_n2  <= NW'(r_d2x) * NW'(r_d2x) + NW'(r_d2y) * NW'(r_d2y);
        r_den <= (EW'(r_d1x) * EW'(r_d2y) - EW'(r_d1y) * EW'(r_d2x)) <<< 1;
        r_e1x <= r_d1x;
        r_e1y <= r_d1y;
        r_e2x <= r_d2x;
        r_e2y <= r_d2y;
        r_bx2 <= r_bx1;
        r_by2 <= r_by1;
    end

    // Stage 3: Cramer numerators (two register stages inside the multipliers).
    logic signed [QW-1:0] w_p1, w_p2, w_p3, w_p4;

    bccf_mul #(.AW(NW), .BW(DW), .PW(QW)) u_m1 (
        .i_clk(i_clk), .i_a(r_n1), .i_b(r_e2y), .o_p(w_p1));
    bccf_mul #(.AW(NW), .BW(DW), .PW(QW)) u_m2 (
        .i_clk(i_clk), .i_a(r_n2), .i_b(r_e1y), .o_p(w_p2));
    bccf_mul #(.AW(NW), .BW(DW), .PW(QW)) u_m3 (
        .i_clk(i_clk), .i_a(r_n2), .i_b(r_e1x), .o_p(w_p3));
    bccf_mul #(.AW(NW), .BW(DW), .PW(QW)) u_m4 (
        .i_clk(i_clk), .i_a(r_n1), .i_b(r_e2x), .o_p(w_p4));

    // The valid bit, denominator and beam follow the partial product stage.
    logic                 r_vm;
    logic signed [EW-1:0] r_denm;
    logic signed [COORD_WIDTH-1:0] r_bxm, r_bym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= r_v2;
        end
        r_denm <= r_den;
        r_bxm  <= r_bx2;
        r_bym  <= r_by2;
    end

    logic                 r_v3;
    logic signed [EW-1:0] r_den3;
    logic signed [COORD_WIDTH-1:0] r_bx3, r_by3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_vm;
        end
        r_den3 <= r_denm;
        r_bx3  <= r_bxm;
        r_by3  <= r_bym;
    end

    // Stage 4: signed numerators to rounding magnitudes (2|n| + |d|) / 2|d|.
    logic                 r_v4, r_dg4, r_sx4, r_sy4;
    logic [MW-1:0]        r_ax4, r_ay4;
    logic [EW:0]          r_dd4;
    logic signed [COORD_WIDTH-1:0] r_bx4, r_by4;
    logic signed [QW-1:0] n_numx, n_numy;
    logic [QW-1:0]        n_mx, n_my;
    logic [EW-1:0]        n_md;

    always_comb begin
        n_numx = w_p1 - w_p2;
        n_numy = w_p3 - w_p4;
        n_mx   = n_numx[QW-1] ? QW'(-n_numx) : QW'(n_numx);
        n_my   = n_numy[QW-1] ? QW'(-n_numy) : QW'(n_numy);
        n_md   = r_den3[EW-1] ? EW'(-r_den3) : EW'(r_den3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_dg4 <= (r_den3 == '0);
        r_sx4 <= n_numx[QW-1] ^ r_den3[EW-1];
        r_sy4 <= n_numy[QW-1] ^ r_den3[EW-1];
        r_ax4 <= {n_mx, 1'b0} + MW'(n_md);
        r_ay4 <= {n_my, 1'b0} + MW'(n_md);
        r_dd4 <= {n_md, 1'b0};
        r_bx4 <= r_bx3;
        r_by4 <= r_by3;
    end

    // Dividers: each tag holds valid, degenerate, sign and beam; valid and degenerate come from Y.
    logic [MW-1:0]          w_qx, w_qy;
    logic [TW-1:0]          w_tx, w_ty;

    bccf_div #(.NW(MW), .DW(EW + 1), .TW(TW)) u_divx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_num(r_ax4), .i_den(r_dd4),
        .i_tag({r_v4, r_dg4, r_sx4, r_bx4}), .o_quo(w_qx), .o_tag(w_tx));
    bccf_div #(.NW(MW), .DW(EW + 1), .TW(TW)) u_divy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_num(r_ay4), .i_den(r_dd4),
        .i_tag({r_v4 & i_rst_n, r_dg4, r_sy4, r_by4}), .o_quo(w_qy),
        .o_tag(w_ty));

    // Stage 5: center, saturation and the sum of squares.
    logic                 r_v5, r_dg5, r_sat5;
    logic signed [31:0]   r_cx5, r_cy5;
    logic [63:0]          n_ss;
    logic signed [42:0]   n_cx, n_cy;
    logic                 n_bigx, n_bigy, n_rbig, n_satx, n_saty;
    logic signed [31:0]   n_clx, n_cly;

    always_comb begin
        n_bigx = (w_qx >> 40) != '0;
        n_bigy = (w_qy >> 40) != '0;
        n_cx   = 43'(signed'(w_tx[COORD_WIDTH-1:0]))
               + (w_tx[COORD_WIDTH] ? -43'(w_qx[39:0]) : 43'(w_qx[39:0]));
        n_cy   = 43'(signed'(w_ty[COORD_WIDTH-1:0]))
               + (w_ty[COORD_WIDTH] ? -43'(w_qy[39:0]) : 43'(w_qy[39:0]));
        n_satx = 1'b0;
        n_saty = 1'b0;
        if (n_bigx) begin
            n_clx = w_tx[COORD_WIDTH] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            n_satx = 1'b1;
        end else if (n_cx > 43'sd2147483647) begin
            n_clx = 32'sh7FFF_FFFF;
            n_satx = 1'b1;
        end else if (n_cx < -43'sd2147483648) begin
            n_clx = 32'sh8000_0000;
            n_satx = 1'b1;
        end else begin
            n_clx = n_cx[31:0];
        end
        if (n_bigy) begin
            n_cly = w_ty[COORD_WIDTH] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            n_saty = 1'b1;
        end else if (n_cy > 43'sd2147483647) begin
            n_cly = 32'sh7FFF_FFFF;
            n_saty = 1'b1;
        end else if (n_cy < -43'sd2147483648) begin
            n_cly = 32'sh8000_0000;
            n_saty = 1'b1;
        end else begin
            n_cly = n_cy[31:0];
        end
        n_rbig = ((w_qx >> 31) != '0) || ((w_qy >> 31) != '0);
        n_ss   = 64'(w_qx[30:0]) * 64'(w_qx[30:0])
               + 64'(w_qy[30:0]) * 64'(w_qy[30:0]);
    end

    logic [64:0] r_ss5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= w_ty[TW-1];
        end
        r_dg5  <= w_ty[TW-2];
        r_sat5 <= n_satx | n_saty | n_rbig;
        r_cx5  <= n_clx;
        r_cy5  <= n_cly;
        r_ss5  <= {n_rbig, n_ss};
    end

    // Square root, tag holds valid, degenerate, saturation, the radius overflow flag and both centers.
    localparam int ST = 3 + 64 + 1;
    logic [32:0]   w_root;
    logic [ST-1:0] w_st;

    bccf_sqrt #(.TW(ST)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s(r_ss5[63:0]),
        .i_tag({r_v5 & i_rst_n, r_dg5, r_sat5, r_ss5[64], r_cx5, r_cy5}),
        .o_root(w_root), .o_tag(w_st));

    logic r_v6;
    logic [1:0] r_st6;
    logic signed [31:0] r_cx6, r_cy6;
    logic [30:0] r_rad6;
    logic n_rsat;

    always_comb begin
        n_rsat = w_st[64] || (w_root > 33'h7FFF_FFFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= w_st[ST-1];
        end
        if (w_st[ST-2]) begin
            r_st6  <= ST_DEGN;
            r_cx6  <= '0;
            r_cy6  <= '0;
            r_rad6 <= '0;
        end else begin
            r_st6  <= (w_st[ST-3] || n_rsat) ? ST_SAT : ST_OK;
            r_cx6  <= w_st[63:32];
            r_cy6  <= w_st[31:0];
            r_rad6 <= n_rsat ? 31'h7FFF_FFFF : w_root[30:0];
        end
    end

    assign o_valid      = r_v6;
    assign o_center_x   = r_cx6;
    assign o_center_y   = r_cy6;
    assign o_radius     = r_rad6;
    assign o_fit_status = r_st6;

    // A degenerate result reports a zero center and radius; this checks the radius and the X center.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fit_status == ST_DEGN |-> o_radius == '0 && o_center_x == '0)
        else $error("degenerate result with nonzero payload");

    // The status code never takes the unused value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fit_status == ST_OK || o_fit_status == ST_DEGN ||
                    o_fit_status == ST_SAT)
        else $error("unused status code");

    // Every valid bit is cleared by reset, so the strobe is never unknown.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(o_valid))
        else $error("unknown result strobe");

endmodule

/* verif/tb_beam_constrained_circle_fit_core.sv */
`timescale 1ns / 1ps

// Self-checking bench for the beam-constrained circle fit core. Hit pairs are
// queued by the stimulus block and handed over by a falling-edge driver, one
// transaction per accepted start. At acceptance, a behavioral circumcircle
// solver in wide integer arithmetic computes the expected center, radius and
// status. A rising-edge monitor compares every o_valid strobe with the oldest
// of those.
module tb_beam_constrained_circle_fit_core;
    import bccf_pkg::*;

    localparam int CW = 20;
    localparam int DRAIN_CYCLES = 400;      // well past the divider and root pipes
    localparam int CYCLE_LIMIT = 300000;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct {
        logic signed [CW-1:0] fx, fy, sx, sy;
    } t_hit_pair;

    typedef struct {
        logic signed [31:0] cx, cy;
        logic [30:0]        rad;
        logic [1:0]         st;
    } t_circle;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_idx = CFG_BEAM_X;
    logic [CW-1:0]        i_cfg_data = '0;
    logic signed [CW-1:0] i_first_x = '0, i_first_y = '0;
    logic signed [CW-1:0] i_second_x = '0, i_second_y = '0;
    logic                 o_valid;
    logic signed [31:0]   o_center_x, o_center_y;
    logic [30:0]          o_radius;
    logic [1:0]           o_fit_status;

    beam_constrained_circle_fit_core #(.COORD_WIDTH(CW)) dut (.*);

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_hit_pair            pending_pairs[$];
    t_circle              expected_fits[$];
    logic signed [CW-1:0] beam_x_mirror = '0, beam_y_mirror = '0;
    int                   sender_idle_pct = 0;
    int                   errors = 0;
    int                   cycles = 0;

    // Integer square root rounded to the nearest integer.
    function automatic logic [63:0] round_sqrt(input logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return (s > r) ? r + 1 : r;
    endfunction

    // Places one center coordinate given the rounded offset magnitude from
    // the beam; flags saturation when it leaves the 32-bit signed range.
    function automatic logic signed [31:0] place_center(input longint beam,
            input logic [127:0] mag, input bit neg, inout bit sat);
        longint v;
        if (mag >= (128'd1 << 40)) begin
            sat = 1'b1;
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        v = neg ? beam - longint'(mag[63:0]) : beam + longint'(mag[63:0]);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Circumcircle through both hits and the beam by Cramer's rule, with the
    // hits taken relative to the beam and quotients rounded half away from zero.
    function automatic t_circle fit_circle(input t_hit_pair p);
        t_circle                r;
        longint                 bx, by;
        logic signed [127:0]    d1x, d1y, d2x, d2y, n1, n2, den, numx, numy;
        logic [127:0]           aden, qx, qy;
        bit                     nx, ny, sat;
        bx = longint'(beam_x_mirror);
        by = longint'(beam_y_mirror);
        d1x = 128'(longint'(p.fx) - bx);
        d1y = 128'(longint'(p.fy) - by);
        d2x = 128'(longint'(p.sx) - bx);
        d2y = 128'(longint'(p.sy) - by);
        n1 = d1x * d1x + d1y * d1y;
        n2 = d2x * d2x + d2y * d2y;
        den = 2 * (d1x * d2y - d1y * d2x);
        sat = 1'b0;
        if (den == 0) begin
            r.cx = '0;
            r.cy = '0;
            r.rad = '0;
            r.st = ST_DEGN;
            return r;
        end
        numx = n1 * d2y - n2 * d1y;
        numy = n2 * d1x - n1 * d2x;
        aden = (den < 0) ? -den : den;
        qx = (2 * ((numx < 0) ? -numx : numx) + aden) / (2 * aden);
        qy = (2 * ((numy < 0) ? -numy : numy) + aden) / (2 * aden);
        nx = (numx < 0) != (den < 0);
        ny = (numy < 0) != (den < 0);
        r.cx = place_center(bx, qx, nx, sat);
        r.cy = place_center(by, qy, ny, sat);
        if (qx >= (128'd1 << 31) || qy >= (128'd1 << 31)) begin
            r.rad = 31'h7FFF_FFFF;
            sat = 1'b1;
        end else begin
            logic [63:0] rt;
            rt = round_sqrt(qx[63:0] * qx[63:0] + qy[63:0] * qy[63:0]);
            if (rt > 64'h7FFF_FFFF) begin
                rt = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
            r.rad = rt[30:0];
        end
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    // Driver: presents the head of the pending queue at the falling edge,
    // idling at random according to the current phase.
    always @(negedge i_clk) begin
        if (i_rst_n && pending_pairs.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
            start      <= 1'b1;
            i_first_x  <= pending_pairs[0].fx;
            i_first_y  <= pending_pairs[0].fy;
            i_second_x <= pending_pairs[0].sx;
            i_second_y <= pending_pairs[0].sy;
        end else begin
            start <= 1'b0;
        end
    end

    // Acceptance and result checking, both at the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("beam_constrained_circle_fit_core: mismatch");
            $finish;
        end
        if (i_rst_n && start && !busy) begin
            expected_fits.insert(expected_fits.size(), fit_circle(pending_pairs[0]));
            void'(pending_pairs.pop_front());
        end
        if (i_rst_n && o_valid) begin
            if (expected_fits.size() == 0) begin
                $display("%0t: result with no transaction outstanding", $time);
                errors <= errors + 1;
            end else begin
                t_circle e;
                e = expected_fits.pop_front();
                if (o_center_x !== e.cx || o_center_y !== e.cy ||
                        o_radius !== e.rad || o_fit_status !== e.st) begin
                    $display("%0t: expected cx=%0d cy=%0d r=%0d st=%0d, got cx=%0d cy=%0d r=%0d st=%0d",
                             $time, e.cx, e.cy, e.rad, e.st,
                             o_center_x, o_center_y, o_radius, o_fit_status);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic write_beam(input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BEAM_X;
        i_cfg_data <= bx;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_BEAM_Y;
        i_cfg_data <= by;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        beam_x_mirror = bx;
        beam_y_mirror = by;
    endtask

    task automatic queue_pair(input logic signed [CW-1:0] fx, fy, sx, sy);
        t_hit_pair p;
        p.fx = fx;
        p.fy = fy;
        p.sx = sx;
        p.sy = sy;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    // Waits for every transaction to come back, then lets the pipe empty.
    task automatic drain();
        while (pending_pairs.size() > 0 || expected_fits.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] near_beam(input logic signed [CW-1:0] b,
            input int span);
        longint v;
        v = longint'(b) + longint'($urandom_range(2 * span)) - longint'(span);
        if (v > longint'(CMAX)) v = longint'(CMAX);
        if (v < longint'(CMIN)) v = longint'(CMIN);
        return v[CW-1:0];
    endfunction

    // Mostly well-formed random pairs: full-range points, points near the
    // beam, and near-collinear pairs that push the center out of range.
    task automatic queue_random(input int n);
        logic signed [CW-1:0] fx, fy;
        int k;
        repeat (n) begin
            k = $urandom_range(9);
            if (k < 4) begin
                queue_pair(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
            end else if (k < 7) begin
                queue_pair(near_beam(beam_x_mirror, 2000), near_beam(beam_y_mirror, 2000),
                           near_beam(beam_x_mirror, 2000), near_beam(beam_y_mirror, 2000));
            end else if (k < 9) begin
                // Second hit on the line through beam and first hit, nudged.
                fx = near_beam(beam_x_mirror, 4000);
                fy = near_beam(beam_y_mirror, 4000);
                queue_pair(fx, fy,
                    near_beam(CW'(beam_x_mirror + 2 * (fx - beam_x_mirror)),
                              $urandom_range(2)),
                    near_beam(CW'(beam_y_mirror + 2 * (fy - beam_y_mirror)),
                              $urandom_range(2)));
            end else begin
                // Exactly degenerate: repeated hit or a hit on the beam.
                fx = CW'($urandom);
                fy = CW'($urandom);
                if ($urandom_range(1))
                    queue_pair(fx, fy, fx, fy);
                else
                    queue_pair(beam_x_mirror, beam_y_mirror, fx, fy);
            end
        end
    endtask

    initial begin
        logic signed [CW-1:0] bxs[5], bys[5];
        int idle_by_phase[5];
        bxs = '{20'sd0, CMAX, CMIN, 20'sd0, 20'sd0};
        bys = '{20'sd0, CMIN, CMAX, 20'sd0, 20'sd0};
        bxs[3] = CW'($urandom);
        bys[3] = CW'($urandom);
        bxs[4] = CW'($urandom_range(4095));
        bys[4] = -$signed(20'($urandom_range(4095)));
        idle_by_phase = '{0, 55, 0, 30, 55};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset beam (the origin): field extremes, symmetric
        // configurations, degenerate cases and out-of-range centers.
        queue_pair(20'sd1024, 20'sd0, 20'sd0, 20'sd1024);
        queue_pair(CMAX, CMAX, CMIN, CMAX);
        queue_pair(CMIN, CMIN, CMAX, CMIN);
        queue_pair(CMAX, CMIN, CMIN, CMIN);
        queue_pair(CMAX, 20'sd0, CMIN, 20'sd0);
        queue_pair(20'sd5, 20'sd7, 20'sd5, 20'sd7);
        queue_pair(20'sd0, 20'sd0, 20'sd300, -20'sd11);
        queue_pair(20'sd3, 20'sd3, -20'sd9, -20'sd9);
        queue_pair(CMAX, 20'sd0, CMIN, 20'sd1);
        queue_pair(CMAX, 20'sd1, CMIN, 20'sd0);
        queue_pair(20'sd1, CMAX, 20'sd0, CMIN);
        queue_pair(CMAX, CMAX, CMIN, CMIN + 20'sd1);
        queue_pair(20'sd2, 20'sd0, 20'sd0, 20'sd2);
        queue_pair(20'sd1, 20'sd0, 20'sd0, -20'sd1);
        queue_pair(20'sd1, 20'sd1, 20'sd1, -20'sd1);
        queue_pair(-20'sd1, 20'sd0, 20'sd0, 20'sd0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_beam(bxs[ph], bys[ph]);
            sender_idle_pct = idle_by_phase[ph];
            if (ph == 1) begin
                // With the beam at a corner, hits at the corners, the beam's own among them.
                queue_pair(CMIN, CMAX, CMAX, CMIN);
                queue_pair(CMIN, CMIN, CMAX, CMAX);
                queue_pair(bxs[ph], bys[ph], CMIN, CMIN);
            end
            queue_random(380);
            drain();
        end

        if (errors == 0) begin
            $display("beam_constrained_circle_fit_core: match");
        end else begin
            $display("beam_constrained_circle_fit_core: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
sv/bccf_pkg.sv
sv/bccf_mul.sv
sv/bccf_div.sv
sv/bccf_sqrt.sv
sv/beam_constrained_circle_fit_core.sv
verif/tb_beam_constrained_circle_fit_core.sv
